FILE: src/rtmp_chp_pkg.sv
`default_nettype none
package rtmp_chp_pkg;

    // field widths
    localparam int unsigned StreamW = 17;
    localparam int unsigned TotalW  = 25;
    localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_CONT  = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    // chunk formats
    localparam logic [1:0] FMT_FULL  = 2'd0;
    localparam logic [1:0] FMT_NOSID = 2'd1;
    localparam logic [1:0] FMT_TS    = 2'd2;
    localparam logic [1:0] FMT_CONT  = 2'd3;

    // message kinds
    localparam logic [2:0] KIND_CHUNK_SIZE = 3'd0;
    localparam logic [2:0] KIND_ACK        = 3'd1;
    localparam logic [2:0] KIND_USER_CTRL  = 3'd2;
    localparam logic [2:0] KIND_WIN_ACK    = 3'd3;
    localparam logic [2:0] KIND_PEER_BW    = 3'd4;
    localparam logic [2:0] KIND_COMMAND    = 3'd5;
    localparam logic [2:0] KIND_UNKNOWN    = 3'd6;

    // message type bytes
    localparam logic [7:0] TYPE_CHUNK_SIZE = 8'h01;
    localparam logic [7:0] TYPE_ACK        = 8'h03;
    localparam logic [7:0] TYPE_USER_CTRL  = 8'h04;
    localparam logic [7:0] TYPE_WIN_ACK    = 8'h05;
    localparam logic [7:0] TYPE_PEER_BW    = 8'h06;
    localparam logic [7:0] TYPE_COMMAND    = 8'h14;

    // decoded packet, handed from the front to the back
    typedef struct packed {
        logic               basic_short;
        logic               in_body;
        logic [1:0]         fmt;
        logic [StreamW-1:0] stream;
        logic [23:0]        stamp;
        logic [23:0]        length;
        logic [7:0]         type_code;
        logic [31:0]        msg_stream;
        logic [3:0]         hdr_size;
        logic [TotalW-1:0]  total;
    } t_hdr_rec;

    // message header length per format
    function automatic logic [3:0] msg_hdr_len(input logic [1:0] fmt);
        logic [3:0] len;
        unique case (fmt)
            FMT_FULL:  len = 4'd11;
            FMT_NOSID: len = 4'd7;
            FMT_TS:    len = 4'd3;
            default:   len = 4'd0;
        endcase
        return len;
    endfunction

    // message kind from type byte
    function automatic logic [2:0] kind_of(input logic [7:0] t);
        logic [2:0] k;
        unique case (t)
            TYPE_CHUNK_SIZE: k = KIND_CHUNK_SIZE;
            TYPE_ACK:        k = KIND_ACK;
            TYPE_USER_CTRL:  k = KIND_USER_CTRL;
            TYPE_WIN_ACK:    k = KIND_WIN_ACK;
            TYPE_PEER_BW:    k = KIND_PEER_BW;
            TYPE_COMMAND:    k = KIND_COMMAND;
            default:         k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

FILE: src/rtmp_chp_front.sv
`default_nettype none
module rtmp_chp_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_beat,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic                  i_last_byte,
    output logic                       o_push,
    output rtmp_chp_pkg::t_hdr_rec     o_rec
);
    import rtmp_chp_pkg::*;

    localparam logic [2:0] PH_FIRST  = 3'd0;
    localparam logic [2:0] PH_EXT1   = 3'd1;
    localparam logic [2:0] PH_EXT2LO = 3'd2;
    localparam logic [2:0] PH_EXT2HI = 3'd3;
    localparam logic [2:0] PH_MSG    = 3'd4;
    localparam logic [2:0] PH_BODY   = 3'd5;

    logic [2:0]         r_phase, n_phase;
    logic [3:0]         r_idx, n_idx;
    logic [1:0]         r_fmt, n_fmt;
    logic [StreamW-1:0] r_stream, n_stream;
    logic [23:0]        r_stamp, n_stamp;
    logic [23:0]        r_length, n_length;
    logic [7:0]         r_type, n_type;
    logic [31:0]        r_msid, n_msid;
    logic [TotalW-1:0]  r_total, n_total;
    logic [3:0]         w_next_idx;
    logic [5:0]         w_csid;
    logic [1:0]         w_enter_fmt;
    logic               w_enter;

    // parser next state for the current byte
    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_fmt       = r_fmt;
        n_stream    = r_stream;
        n_stamp     = r_stamp;
        n_length    = r_length;
        n_type      = r_type;
        n_msid      = r_msid;
        n_total     = (r_total != TotalMax) ? r_total + 1'b1 : r_total;
        w_next_idx  = r_idx + 4'd1;
        w_csid      = i_data_byte[5:0];
        w_enter     = 1'b0;
        w_enter_fmt = r_fmt;

        unique case (r_phase)
            PH_EXT1: begin
                n_stream = StreamW'(64) + {9'd0, i_data_byte};
                w_enter  = 1'b1;
            end
            PH_EXT2LO: begin
                n_stream = StreamW'(64) + {9'd0, i_data_byte};
                n_phase  = PH_EXT2HI;
            end
            PH_EXT2HI: begin
                n_stream = r_stream + {1'b0, i_data_byte, 8'd0};
                w_enter  = 1'b1;
            end
            PH_MSG: begin
                unique case (r_idx)
                    4'd0:    n_stamp[23:16]   = i_data_byte;
                    4'd1:    n_stamp[15:8]    = i_data_byte;
                    4'd2:    n_stamp[7:0]     = i_data_byte;
                    4'd3:    n_length[23:16]  = i_data_byte;
                    4'd4:    n_length[15:8]   = i_data_byte;
                    4'd5:    n_length[7:0]    = i_data_byte;
                    4'd6:    n_type           = i_data_byte;
                    4'd7:    n_msid[7:0]      = i_data_byte;
                    4'd8:    n_msid[15:8]     = i_data_byte;
                    4'd9:    n_msid[23:16]    = i_data_byte;
                    4'd10:   n_msid[31:24]    = i_data_byte;
                    default: n_type           = r_type;
                endcase
                n_idx = w_next_idx;
                if (w_next_idx >= msg_hdr_len(r_fmt)) begin
                    n_phase = PH_BODY;
                    n_idx   = n_total[3:0];
                end
            end
            PH_BODY: begin
                n_phase = PH_BODY;
            end
            default: begin
                // first byte of the basic header, also for unused codes
                n_fmt       = i_data_byte[7:6];
                w_enter_fmt = i_data_byte[7:6];
                n_stamp     = '0;
                n_length    = '0;
                n_type      = '0;
                n_msid      = '0;
                if (w_csid == 6'd0) begin
                    n_stream = StreamW'(64);
                    n_phase  = PH_EXT1;
                end else if (w_csid == 6'd1) begin
                    n_stream = StreamW'(64);
                    n_phase  = PH_EXT2LO;
                end else begin
                    n_stream = {11'd0, w_csid};
                    w_enter  = 1'b1;
                end
            end
        endcase

        // basic header complete: go to the message header or straight to the body
        if (w_enter) begin
            if (msg_hdr_len(w_enter_fmt) == 4'd0) begin
                n_phase = PH_BODY;
                n_idx   = n_total[3:0];
            end else begin
                n_phase = PH_MSG;
                n_idx   = 4'd0;
            end
        end
    end

    // record of the finished packet
    always_comb begin
        o_push            = i_beat & i_last_byte;
        o_rec.basic_short = (n_phase == PH_EXT1) || (n_phase == PH_EXT2LO) ||
                            (n_phase == PH_EXT2HI);
        o_rec.in_body     = (n_phase == PH_BODY);
        o_rec.fmt         = n_fmt;
        o_rec.stream      = n_stream;
        o_rec.stamp       = n_stamp;
        o_rec.length      = n_length;
        o_rec.type_code   = n_type;
        o_rec.msg_stream  = n_msid;
        o_rec.hdr_size    = n_idx;
        o_rec.total       = n_total;
    end

    // parser state, cleared after the last beat of a packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_beat && i_last_byte)) begin
            r_phase  <= PH_FIRST;
            r_idx    <= '0;
            r_fmt    <= '0;
            r_stream <= '0;
            r_stamp  <= '0;
            r_length <= '0;
            r_type   <= '0;
            r_msid   <= '0;
            r_total  <= '0;
        end else if (i_beat) begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_fmt    <= n_fmt;
            r_stream <= n_stream;
            r_stamp  <= n_stamp;
            r_length <= n_length;
            r_type   <= n_type;
            r_msid   <= n_msid;
            r_total  <= n_total;
        end
    end

endmodule
`default_nettype wire

FILE: src/rtmp_chp_queue.sv
`default_nettype none
module rtmp_chp_queue (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire rtmp_chp_pkg::t_hdr_rec i_rec,
    input  wire logic                  i_pop,
    output logic                       o_full,
    output logic                       o_valid,
    output rtmp_chp_pkg::t_hdr_rec     o_rec
);
    import rtmp_chp_pkg::*;

    t_hdr_rec   r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_rec   = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/rtmp_chp_back.sv
`default_nettype none
module rtmp_chp_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_rec_valid,
    input  wire rtmp_chp_pkg::t_hdr_rec            i_rec,
    output logic                                   o_pop,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [1:0]                             o_status,
    output logic [1:0]                             o_chunk_format,
    output logic [rtmp_chp_pkg::StreamW-1:0]       o_chunk_stream,
    output logic [23:0]                            o_time_stamp,
    output logic [23:0]                            o_body_length,
    output logic [7:0]                             o_type_code,
    output logic [31:0]                            o_message_stream,
    output logic [2:0]                             o_message_kind,
    output logic [rtmp_chp_pkg::TotalW-1:0]        o_consumed_count
);
    import rtmp_chp_pkg::*;

    logic              r_valid;
    logic [1:0]        w_status;
    logic [TotalW:0]   w_need;
    logic [TotalW-1:0] w_consumed;

    assign o_pop       = i_rec_valid && (!r_valid || i_out_ready);
    assign o_out_valid = r_valid;

    // status and consumed count
    always_comb begin
        w_need     = {{(TotalW-3){1'b0}}, i_rec.hdr_size} + {2'd0, i_rec.length};
        w_consumed = '0;
        priority if (i_rec.basic_short) begin
            w_status = ST_SHORT;
        end else if (i_rec.fmt == FMT_CONT) begin
            w_status = ST_CONT;
        end else if (!i_rec.in_body) begin
            w_status = ST_SHORT;
        end else if ({1'b0, i_rec.total} < w_need) begin
            w_status = ST_SHORT;
        end else begin
            w_status   = ST_OK;
            w_consumed = i_rec.total;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_status         <= w_status;
            o_chunk_format   <= i_rec.fmt;
            o_chunk_stream   <= i_rec.stream;
            o_time_stamp     <= i_rec.stamp;
            o_body_length    <= i_rec.length;
            o_type_code      <= i_rec.type_code;
            o_message_stream <= i_rec.msg_stream;
            o_message_kind   <= kind_of(i_rec.type_code);
            o_consumed_count <= w_consumed;
        end
    end

endmodule
`default_nettype wire

FILE: src/rtmp_chunk_header_parser.sv
`default_nettype none
// channel   valid         ready         payload
// input     i_in_valid    o_in_ready    i_data_byte, i_last_byte
// output    o_out_valid   i_out_ready   o_status .. o_consumed_count
//
// one byte is taken per cycle while the queue has room; the result of a packet is written into
// the queue at the edge that takes its last byte, then into the output register when it is popped.
// the front stalls only when the two-entry queue of finished packets is full.
// reset (synchronous, active low) returns the parser to the first header byte and empties
// the queue and the output register.
module rtmp_chunk_header_parser (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [7:0]                        i_data_byte,
    input  wire logic                              i_last_byte,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [1:0]                             o_status,
    output logic [1:0]                             o_chunk_format,
    output logic [rtmp_chp_pkg::StreamW-1:0]       o_chunk_stream,
    output logic [23:0]                            o_time_stamp,
    output logic [23:0]                            o_body_length,
    output logic [7:0]                             o_type_code,
    output logic [31:0]                            o_message_stream,
    output logic [2:0]                             o_message_kind,
    output logic [rtmp_chp_pkg::TotalW-1:0]        o_consumed_count
);
    import rtmp_chp_pkg::*;

    logic     w_beat;
    logic     w_push;
    logic     w_pop;
    logic     w_full;
    logic     w_q_valid;
    t_hdr_rec w_front_rec;
    t_hdr_rec w_q_rec;

    assign o_in_ready = !w_full;
    assign w_beat     = i_in_valid && !w_full;

    // byte parser
    rtmp_chp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (w_beat),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (w_push),
        .o_rec       (w_front_rec)
    );

    // finished packets awaiting the result stage
    rtmp_chp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_front_rec),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_rec   (w_q_rec)
    );

    // result stage
    rtmp_chp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rec_valid      (w_q_valid),
        .i_rec            (w_q_rec),
        .o_pop            (w_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_chunk_format   (o_chunk_format),
        .o_chunk_stream   (o_chunk_stream),
        .o_time_stamp     (o_time_stamp),
        .o_body_length    (o_body_length),
        .o_type_code      (o_type_code),
        .o_message_stream (o_message_stream),
        .o_message_kind   (o_message_kind),
        .o_consumed_count (o_consumed_count)
    );

endmodule
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
module tb;
    import rtmp_chp_pkg::*;

    localparam int unsigned ITEMS       = 1900;
    localparam int unsigned MIN_PACKETS = 60;
    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned TAIL_CYCLES = 10;

    // parser phase codes
    localparam logic [2:0] PH_FIRST  = 3'd0;
    localparam logic [2:0] PH_EXT1   = 3'd1;
    localparam logic [2:0] PH_EXT2LO = 3'd2;
    localparam logic [2:0] PH_EXT2HI = 3'd3;
    localparam logic [2:0] PH_MSG    = 3'd4;
    localparam logic [2:0] PH_BODY   = 3'd5;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_byte_beat;

    typedef struct packed {
        logic [1:0]         status;
        logic [1:0]         fmt;
        logic [StreamW-1:0] stream;
        logic [23:0]        stamp;
        logic [23:0]        length;
        logic [7:0]         type_code;
        logic [31:0]        msg_stream;
        logic [2:0]         kind;
        logic [TotalW-1:0]  consumed;
    } t_hdr_result;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic i_last_byte = 1'b0;
    logic i_out_ready = 1'b0;

    logic               o_in_ready;
    logic               o_out_valid;
    logic [1:0]         o_status;
    logic [1:0]         o_chunk_format;
    logic [StreamW-1:0] o_chunk_stream;
    logic [23:0]        o_time_stamp;
    logic [23:0]        o_body_length;
    logic [7:0]         o_type_code;
    logic [31:0]        o_message_stream;
    logic [2:0]         o_message_kind;
    logic [TotalW-1:0]  o_consumed_count;

    rtmp_chunk_header_parser u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_chunk_format   (o_chunk_format),
        .o_chunk_stream   (o_chunk_stream),
        .o_time_stamp     (o_time_stamp),
        .o_body_length    (o_body_length),
        .o_type_code      (o_type_code),
        .o_message_stream (o_message_stream),
        .o_message_kind   (o_message_kind),
        .o_consumed_count (o_consumed_count)
    );

    // packet bytes still to send, and decoded headers still to arrive
    t_byte_beat  pkt_bytes_q [$];
    t_hdr_result hdr_expect_q [$];
    logic [8:0]  directed_seq [32];

    int unsigned n_items, n_packets, sent_cnt, split_a, split_b;
    int unsigned stall_cycles, mismatches, hold_left;
    bit          hold_done, in_acc;

    // parser state mirror
    logic [2:0]         ph_q;
    logic [3:0]         hdr_idx_q;
    logic [1:0]         fmt_q;
    logic [StreamW-1:0] sid_q;
    logic [23:0]        stamp_q, len_q;
    logic [7:0]         type_q;
    logic [31:0]        msid_q;
    logic [TotalW-1:0]  total_q;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [3:0] hdr_bytes(input logic [1:0] f);
        case (f)
            FMT_FULL:  return 4'd11;
            FMT_NOSID: return 4'd7;
            FMT_TS:    return 4'd3;
            default:   return 4'd0;
        endcase
    endfunction

    function automatic logic [2:0] kind_for_type(input logic [7:0] t);
        case (t)
            TYPE_CHUNK_SIZE: return KIND_CHUNK_SIZE;
            TYPE_ACK:        return KIND_ACK;
            TYPE_USER_CTRL:  return KIND_USER_CTRL;
            TYPE_WIN_ACK:    return KIND_WIN_ACK;
            TYPE_PEER_BW:    return KIND_PEER_BW;
            TYPE_COMMAND:    return KIND_COMMAND;
            default:         return KIND_UNKNOWN;
        endcase
    endfunction

    function automatic void clear_parser();
        ph_q      = PH_FIRST;
        hdr_idx_q = 4'd0;
        fmt_q     = 2'd0;
        sid_q     = '0;
        stamp_q   = 24'd0;
        len_q     = 24'd0;
        type_q    = 8'd0;
        msid_q    = 32'd0;
        total_q   = '0;
    endfunction

    // after the basic header: straight to the body when the format has no message header
    function automatic void enter_msg_hdr();
        if (hdr_bytes(fmt_q) == 4'd0) begin
            ph_q      = PH_BODY;
            hdr_idx_q = total_q[3:0];
        end else begin
            ph_q      = PH_MSG;
            hdr_idx_q = 4'd0;
        end
    endfunction

    // advance the mirror by one byte; returns 1 with the decoded header on the last byte
    function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                      output t_hdr_result r);
        logic [25:0] need;
        r = '0;
        if (total_q != TotalMax) total_q = total_q + 1'b1;
        case (ph_q)
            PH_EXT1: begin
                sid_q = 17'd64 + 17'(b);
                enter_msg_hdr();
            end
            PH_EXT2LO: begin
                sid_q = 17'd64 + 17'(b);
                ph_q  = PH_EXT2HI;
            end
            PH_EXT2HI: begin
                sid_q = sid_q + {1'b0, b, 8'h00};
                enter_msg_hdr();
            end
            PH_MSG: begin
                case (hdr_idx_q)
                    4'd0:  stamp_q[23:16] = b;
                    4'd1:  stamp_q[15:8]  = b;
                    4'd2:  stamp_q[7:0]   = b;
                    4'd3:  len_q[23:16]   = b;
                    4'd4:  len_q[15:8]    = b;
                    4'd5:  len_q[7:0]     = b;
                    4'd6:  type_q         = b;
                    4'd7:  msid_q[7:0]    = b;
                    4'd8:  msid_q[15:8]   = b;
                    4'd9:  msid_q[23:16]  = b;
                    4'd10: msid_q[31:24]  = b;
                    default: ;
                endcase
                hdr_idx_q = hdr_idx_q + 1'b1;
                if (hdr_idx_q >= hdr_bytes(fmt_q)) begin
                    ph_q      = PH_BODY;
                    hdr_idx_q = total_q[3:0];
                end
            end
            PH_BODY: ;
            default: begin
                fmt_q   = b[7:6];
                stamp_q = 24'd0;
                len_q   = 24'd0;
                type_q  = 8'd0;
                msid_q  = 32'd0;
                if (b[5:0] == 6'd0) begin
                    sid_q = 17'd64;
                    ph_q  = PH_EXT1;
                end else if (b[5:0] == 6'd1) begin
                    sid_q = 17'd64;
                    ph_q  = PH_EXT2LO;
                end else begin
                    sid_q = 17'(b[5:0]);
                    enter_msg_hdr();
                end
            end
        endcase
        if (!last) return 1'b0;

        need = 26'(hdr_idx_q) + 26'(len_q);
        if (ph_q == PH_EXT1 || ph_q == PH_EXT2LO || ph_q == PH_EXT2HI) begin
            r.status = ST_SHORT;
        end else if (fmt_q == FMT_CONT) begin
            r.status = ST_CONT;
        end else if (ph_q != PH_BODY || {1'b0, total_q} < need) begin
            r.status = ST_SHORT;
        end else begin
            r.status   = ST_OK;
            r.consumed = total_q;
        end
        r.fmt        = fmt_q;
        r.stream     = sid_q;
        r.stamp      = stamp_q;
        r.length     = len_q;
        r.type_code  = type_q;
        r.msg_stream = msid_q;
        r.kind       = kind_for_type(type_q);
        clear_parser();
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic int unsigned idle_pct(input bit sender);
        if (sent_cnt < split_a) return sender ? 17 : 69;
        if (sent_cnt < split_b) return sender ? 69 : 17;
        return 0;
    endfunction

    task automatic push_beat(input logic [7:0] b, input logic last);
        t_byte_beat bt;
        bt.data = b;
        bt.last = last;
        pkt_bytes_q.push_back(bt);
        n_items++;
        if (last) n_packets++;
    endtask

    // mostly well-formed packets with random content, some cut short, some line noise
    task automatic add_random_packet();
        logic [7:0]  pkt [$];
        logic [7:0]  hb [11];
        logic [1:0]  f;
        logic [23:0] ts, ln;
        logic [7:0]  ty;
        logic [31:0] ms;
        int unsigned shape, body_n, keep;
        shape = $urandom_range(99);
        if (shape < 8) begin
            repeat ($urandom_range(1, 16)) pkt.push_back(8'($urandom));
        end else begin
            f = 2'($urandom_range(3));
            case ($urandom_range(2))
                0: pkt.push_back({f, 6'($urandom_range(2, 63))});
                1: begin
                    pkt.push_back({f, 6'd0});
                    pkt.push_back(8'($urandom));
                end
                default: begin
                    pkt.push_back({f, 6'd1});
                    pkt.push_back(8'($urandom));
                    pkt.push_back(8'($urandom));
                end
            endcase
            ts = 24'($urandom);
            ln = ($urandom_range(99) < 6) ? 24'($urandom) : 24'($urandom_range(24));
            case ($urandom_range(9))
                0: ty = TYPE_CHUNK_SIZE;
                1: ty = TYPE_ACK;
                2: ty = TYPE_USER_CTRL;
                3: ty = TYPE_WIN_ACK;
                4: ty = TYPE_PEER_BW;
                5: ty = TYPE_COMMAND;
                default: ty = 8'($urandom);
            endcase
            ms = 32'($urandom);
            hb = '{ts[23:16], ts[15:8], ts[7:0], ln[23:16], ln[15:8], ln[7:0], ty,
                   ms[7:0], ms[15:8], ms[23:16], ms[31:24]};
            for (int i = 0; i < hdr_bytes(f); i++) pkt.push_back(hb[i]);
            // body as long as the header says (formats 0 and 1), capped at 30 so huge lengths stay short
            if (f == FMT_FULL || f == FMT_NOSID) body_n = (ln > 30) ? 30 : ln;
            else body_n = $urandom_range(4);
            if ($urandom_range(3) == 0) body_n += $urandom_range(1, 3);
            repeat (body_n) pkt.push_back(8'($urandom));
            // truncate anywhere: basic header, message header or body
            if (shape < 20) begin
                keep = $urandom_range(1, pkt.size());
                while (pkt.size() > keep) void'(pkt.pop_back());
            end
        end
        foreach (pkt[i]) push_beat(pkt[i], i == pkt.size() - 1);
    endtask

    // sender: offer the next byte at the falling edge, hold it until taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && !in_acc)) begin
            if (pkt_bytes_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
                i_in_valid  <= 1'b1;
                i_data_byte <= pkt_bytes_q[0].data;
                i_last_byte <= pkt_bytes_q[0].last;
            end else begin
                i_in_valid  <= 1'b0;
                i_data_byte <= 8'($urandom);
            end
        end
    end

    // receiver: random stalls plus one long hold-off to back the block up
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && i_rst_n && sent_cnt >= split_b + 20) begin
            hold_done   = 1'b1;
            hold_left   = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    // monitor: check results, mirror accepted bytes, watch for a stuck run
    always @(posedge i_clk) begin : monitor
        t_hdr_result want, pred;
        bit out_acc;
        in_acc  = i_rst_n && i_in_valid && o_in_ready;
        out_acc = i_rst_n && o_out_valid && i_out_ready;
        if (!i_rst_n) clear_parser();

        if (out_acc) begin
            if (hdr_expect_q.size() == 0) begin
                $error("result beat with no header expected");
                mismatches++;
            end else begin
                want = hdr_expect_q.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("chunk_format", 32'(want.fmt), 32'(o_chunk_format));
                check_field("chunk_stream", 32'(want.stream), 32'(o_chunk_stream));
                check_field("time_stamp", 32'(want.stamp), 32'(o_time_stamp));
                check_field("body_length", 32'(want.length), 32'(o_body_length));
                check_field("type_code", 32'(want.type_code), 32'(o_type_code));
                check_field("message_stream", want.msg_stream, o_message_stream);
                check_field("message_kind", 32'(want.kind), 32'(o_message_kind));
                check_field("consumed_count", 32'(want.consumed), 32'(o_consumed_count));
            end
        end

        if (in_acc) begin
            if (parse_byte(i_data_byte, i_last_byte, pred)) hdr_expect_q.push_back(pred);
            void'(pkt_bytes_q.pop_front());
            sent_cnt++;
        end

        if (in_acc || out_acc || !i_rst_n) stall_cycles = 0;
        else stall_cycles++;
    end

    initial begin
        clear_parser();
        // directed packets, bit 8 marks the last byte
        directed_seq = '{
            // continuation, largest one-byte id
            9'h1FF,
            // format 0 ending right after the basic header
            9'h102,
            // ends inside the two-byte id
            9'h100,
            // three-byte id cut after its low byte
            9'h041, 9'h1FF,
            // largest three-byte id on a continuation
            9'h0C1, 9'h0FF, 9'h1FF,
            // message header cut after one byte
            9'h040, 9'h011, 9'h122,
            // full header at the extremes, command type, one body byte
            9'h003, 9'h0FF, 9'h0FF, 9'h0FF, 9'h000, 9'h000, 9'h001, 9'h014,
            9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h1A5,
            // format 1 with maximum length and no body
            9'h07F, 9'h000, 9'h000, 9'h000, 9'h0FF, 9'h0FF, 9'h0FF, 9'h105
        };
        foreach (directed_seq[i]) push_beat(directed_seq[i][7:0], directed_seq[i][8]);
        while (n_items < ITEMS || n_packets < MIN_PACKETS) add_random_packet();
        split_a = n_items / 3;
        split_b = 2 * n_items / 3;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while ((pkt_bytes_q.size() != 0 || hdr_expect_q.size() != 0)
               && stall_cycles < STALL_LIMIT)
            @(posedge i_clk);
        if (stall_cycles < STALL_LIMIT) repeat (TAIL_CYCLES) @(posedge i_clk);

        if (stall_cycles < STALL_LIMIT && mismatches == 0 && hdr_expect_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
